// ----- rtl/core/cnv_pkg.sv -----
// cnv_pkg: shared types, codes and helpers for the card number validator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cnv_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BOUND_W   = 5;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned SUM_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BOUND_W-1:0] MIN_DIGITS_RST = 5'd13;
  localparam logic [BOUND_W-1:0] MAX_DIGITS_RST = 5'd19;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_LEN_ERR   = 2'd1,
    ST_DIGIT_ERR = 2'd2,
    ST_LUHN_FAIL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_SPACE = 2'd1,
    K_DIGIT = 2'd2,
    K_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              no_char;
    logic              is_last;
  } req_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] kept_length;
  } rsp_word_t;

  // classified character as queued between front and back
  typedef struct packed {
    kind_t            kind;
    logic [SUM_W-1:0] digit;
    logic [SUM_W-1:0] doubled;
    logic             is_last;
  } cls_t;

  function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/core/cnv_front.sv -----
// cnv_front: classifies one input character (skip, whitespace, digit, other)
// and precomputes the digit and its Luhn-doubled value. Depends on cnv_pkg.
`timescale 1ns / 1ps

module cnv_front (
  input  cnv_pkg::req_word_t req_data,
  output cnv_pkg::cls_t      cls
);
  import cnv_pkg::*;

  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] d8;
  logic [SUM_W:0]    dbl;
  logic              is_space;
  logic              is_digit;

  assign c        = req_data.char_code;
  assign d8       = c - 8'd48;
  assign is_space = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  assign is_digit = (c >= 8'd48) && (c <= 8'd57);
  assign dbl      = {d8[SUM_W-1:0], 1'b0};

  always_comb begin
    cls.is_last = req_data.is_last;
    cls.digit   = d8[SUM_W-1:0];
    cls.doubled = (dbl > 5'd9) ? SUM_W'(dbl - 5'd9) : dbl[SUM_W-1:0];
    if (req_data.no_char) begin
      cls.kind = K_NONE;
    end else if (is_space) begin
      cls.kind = K_SPACE;
    end else if (is_digit) begin
      cls.kind = K_DIGIT;
    end else begin
      cls.kind = K_OTHER;
    end
  end

endmodule

// ----- rtl/core/cnv_queue.sv -----
// cnv_queue: short register FIFO of classified characters between front and back.
// Depends on cnv_pkg.
`timescale 1ns / 1ps

module cnv_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  cnv_pkg::cls_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output cnv_pkg::cls_t rd_data,
  output logic          empty
);
  import cnv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/cnv_back.sv -----
// cnv_back: accumulates length, non-digit flag and both Luhn parity sums,
// and registers the status word on the last character. Depends on cnv_pkg.
`timescale 1ns / 1ps

module cnv_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cnv_pkg::BOUND_W-1:0]     min_digits,
  input  logic [cnv_pkg::BOUND_W-1:0]     max_digits,
  input  cnv_pkg::cls_t                   cls,
  input  logic                            cls_avail,
  output logic                            pop,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output cnv_pkg::rsp_word_t              rsp_data
);
  import cnv_pkg::*;

  logic [LEN_W-1:0] length_count, length_count_next;
  logic             non_digit_seen, non_digit_seen_next;
  logic             any_char_seen, any_char_seen_next;
  logic [SUM_W-1:0] sum_even_doubled, sum_even_doubled_next;
  logic [SUM_W-1:0] sum_odd_doubled, sum_odd_doubled_next;
  logic             saturated;
  logic             even_pos;
  logic             keep;
  logic [SUM_W-1:0] final_sum;
  status_t          status;

  assign pop       = cls_avail && (!cls.is_last || !rsp_valid || !rsp_stall);
  assign saturated = length_count[LEN_W-1];
  assign even_pos  = !length_count[0];
  assign keep      = (cls.kind == K_DIGIT) || (cls.kind == K_OTHER);

  always_comb begin
    any_char_seen_next    = any_char_seen || (cls.kind != K_NONE);
    non_digit_seen_next   = non_digit_seen || (cls.kind == K_OTHER);
    length_count_next     = (keep && !saturated) ? length_count + 1'b1 : length_count;
    sum_even_doubled_next = sum_even_doubled;
    sum_odd_doubled_next  = sum_odd_doubled;
    if ((cls.kind == K_DIGIT) && !saturated) begin
      sum_even_doubled_next = add_mod10(sum_even_doubled, even_pos ? cls.doubled : cls.digit);
      sum_odd_doubled_next  = add_mod10(sum_odd_doubled, even_pos ? cls.digit : cls.doubled);
    end
    final_sum = length_count_next[0] ? sum_odd_doubled_next : sum_even_doubled_next;
    if (!any_char_seen_next) begin
      status = ST_LEN_ERR;
    end else if (non_digit_seen_next) begin
      status = ST_DIGIT_ERR;
    end else if ((length_count_next < {1'b0, min_digits}) ||
                 (length_count_next > {1'b0, max_digits})) begin
      status = ST_LEN_ERR;
    end else if (final_sum != '0) begin
      status = ST_LUHN_FAIL;
    end else begin
      status = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count     <= '0;
      non_digit_seen   <= 1'b0;
      any_char_seen    <= 1'b0;
      sum_even_doubled <= '0;
      sum_odd_doubled  <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      if (pop && cls.is_last) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (pop) begin
        if (cls.is_last) begin
          length_count     <= '0;
          non_digit_seen   <= 1'b0;
          any_char_seen    <= 1'b0;
          sum_even_doubled <= '0;
          sum_odd_doubled  <= '0;
        end else begin
          length_count     <= length_count_next;
          non_digit_seen   <= non_digit_seen_next;
          any_char_seen    <= any_char_seen_next;
          sum_even_doubled <= sum_even_doubled_next;
          sum_odd_doubled  <= sum_odd_doubled_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cls.is_last) begin
      rsp_data.status      <= status;
      rsp_data.kept_length <= length_count_next;
    end
  end

endmodule

// ----- rtl/core/card_number_validator.sv -----
// card_number_validator: top level, Luhn card number check over a character stream.
// Instantiates cnv_front, cnv_queue and cnv_back; depends on cnv_pkg.
`timescale 1ns / 1ps

// Usage:
//   req channel (req_valid/req_stall/req_data): one character word per cycle
//   while req_stall is low, char_code plus no_char and is_last flags.
//   Whitespace is dropped, all other characters are counted (saturating at 32).
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one status word per string,
//   produced for the word marked is_last, carrying status and kept_length.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 min_digits,
//   index 1 max_digits; cfg_ready is always high. Write only while idle.
// Throughput: one character word per cycle while req_stall is low.
// Output path: the last word is written into the queue, then popped by the back end,
//   which registers the status word; a held status word can delay the pop.
// Reset: bounds return to 13 and 19, queue and string state clear, no word out.
// Stall: rsp_stall holds the status word; further characters still drain into
//   the back end until the next last word, then the queue (QUEUE_DEPTH words)
//   fills and req_stall rises.
module card_number_validator #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  cnv_pkg::req_word_t                req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output cnv_pkg::rsp_word_t                rsp_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cnv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cnv_pkg::BOUND_W-1:0]       cfg_data
);
  import cnv_pkg::*;

  logic [BOUND_W-1:0] min_digits;
  logic [BOUND_W-1:0] max_digits;
  cls_t               front_cls;
  cls_t               back_cls;
  logic               q_full;
  logic               q_empty;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign req_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_digits <= MIN_DIGITS_RST;
      max_digits <= MAX_DIGITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_DIGITS: min_digits <= cfg_data;
        CFG_MAX_DIGITS: max_digits <= cfg_data;
        default: ;
      endcase
    end
  end

  cnv_front u_front (
    .req_data (req_data),
    .cls      (front_cls)
  );

  cnv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (req_valid),
    .wr_data (front_cls),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (back_cls),
    .empty   (q_empty)
  );

  cnv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .min_digits (min_digits),
    .max_digits (max_digits),
    .cls        (back_cls),
    .cls_avail  (!q_empty),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data)
  );

endmodule

// ----- rtl/core/cnv_checker.sv -----
// cnv_checker: port-level assertions for card_number_validator, bound to the top.
// Depends on cnv_pkg.
`timescale 1ns / 1ps

module cnv_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input cnv_pkg::rsp_word_t rsp_data,
  input logic               cfg_ready
);
  import cnv_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled status word changed");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.kept_length <= 6'd32)
    else $error("kept length above saturation");

  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_VALID) |-> rsp_data.kept_length <= 6'd31)
    else $error("valid status with out-of-range length");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && cfg_ready)
    else $error("output active right after reset");

endmodule

bind card_number_validator cnv_checker u_cnv_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data),
  .cfg_ready (cfg_ready)
);
